// ===== sv/deq_pkg.sv =====
package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = PTR_W + 1;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_NOP        = 3'd4;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]            cmd;
      logic [DATA_WIDTH-1:0] data_in;
   } deq_req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] popped_value;
      logic [DATA_WIDTH-1:0] front_value;
      logic [DATA_WIDTH-1:0] back_value;
      logic [CNT_W-1:0]      entry_total;
      logic                  is_empty;
      logic [1:0]            status;
   } deq_rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOOK,
      S_DONE
   } deq_state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic look;
      logic done;
   } deq_ctrl_type;

endpackage

// ===== sv/deq_ctrl.sv =====
module deq_ctrl
   import deq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output deq_ctrl_type ctrl
);

   deq_state_type state_ff;
   deq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            state_in = start ? S_EXEC : S_IDLE;
         end
         S_EXEC: begin
            state_in = S_LOOK;
         end
         S_LOOK: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = start ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            ctrl.load = start;
         end
         S_EXEC: begin
            ctrl.exec = 1'b1;
            busy      = 1'b1;
         end
         S_LOOK: begin
            ctrl.look = 1'b1;
            busy      = 1'b1;
         end
         S_DONE: begin
            ctrl.done = 1'b1;
            ctrl.load = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/deq_datapath.sv =====
module deq_datapath
   import deq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  deq_ctrl_type ctrl,
   input  deq_req_type  req,
   output logic         rsp_strobe,
   output deq_rsp_type  rsp
);

   function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
      return r[PTR_W-1:0];
   endfunction

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [2:0]            cmd_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [PTR_W-1:0]      front_ff;
   logic [PTR_W-1:0]      front_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [1:0]            status_ff;
   logic [1:0]            status_in;
   logic                  pop_ok_ff;
   logic                  pop_ok_in;
   logic [DATA_WIDTH-1:0] popped_ff;
   logic [DATA_WIDTH-1:0] rd0_ff;
   logic [DATA_WIDTH-1:0] rd1_ff;

   logic                  is_push;
   logic                  is_pop;
   logic                  full;
   logic                  empty;
   logic [PTR_W-1:0]      front_dec;
   logic [PTR_W-1:0]      front_inc;
   logic [PTR_W-1:0]      tail_idx;
   logic [PTR_W-1:0]      back_idx;
   logic [PTR_W-1:0]      pop_addr;
   logic [PTR_W-1:0]      rd0_addr;
   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;

   assign is_push = (cmd_ff == CMD_PUSH_FRONT) || (cmd_ff == CMD_PUSH_BACK);
   assign is_pop  = (cmd_ff == CMD_POP_FRONT) || (cmd_ff == CMD_POP_BACK);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);

   assign front_dec = (front_ff == '0) ? PTR_W'(DEPTH - 1) : (front_ff - 1'b1);
   assign front_inc = (front_ff == PTR_W'(DEPTH - 1)) ? '0 : (front_ff + 1'b1);
   assign tail_idx  = ring_wrap({1'b0, front_ff} + SUM_W'(count_ff));
   assign back_idx  = ring_wrap({1'b0, front_ff} + SUM_W'(count_ff - 1'b1));
   assign pop_addr  = (cmd_ff == CMD_POP_FRONT) ? front_ff : back_idx;
   assign rd0_addr  = ctrl.look ? front_ff : pop_addr;

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = STAT_DONE;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = tail_idx;
      priority if (is_push && full) begin
         status_in = STAT_FULL;
      end else if (is_pop && empty) begin
         status_in = STAT_EMPTY;
      end else if (cmd_ff == CMD_PUSH_FRONT) begin
         front_in = front_dec;
         count_in = count_ff + 1'b1;
         wr_en    = 1'b1;
         wr_addr  = front_dec;
      end else if (cmd_ff == CMD_PUSH_BACK) begin
         count_in = count_ff + 1'b1;
         wr_en    = 1'b1;
      end else if (cmd_ff == CMD_POP_FRONT) begin
         front_in  = front_inc;
         count_in  = count_ff - 1'b1;
         pop_ok_in = 1'b1;
      end else if (cmd_ff == CMD_POP_BACK) begin
         count_in  = count_ff - 1'b1;
         pop_ok_in = 1'b1;
      end else begin
         status_in = STAT_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (ctrl.exec) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff  <= req.cmd;
         data_ff <= req.data_in;
      end
      if (ctrl.exec) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
      if (ctrl.look) begin
         popped_ff <= pop_ok_ff ? rd0_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec && wr_en) begin
         mem[wr_addr] <= data_ff;
      end
      rd0_ff <= mem[rd0_addr];
      rd1_ff <= mem[back_idx];
   end

   assign rsp_strobe       = ctrl.done;
   assign rsp.popped_value = popped_ff;
   assign rsp.front_value  = empty ? '0 : rd0_ff;
   assign rsp.back_value   = empty ? '0 : rd1_ff;
   assign rsp.entry_total  = count_ff;
   assign rsp.is_empty     = empty;
   assign rsp.status       = status_ff;

endmodule

// ===== sv/double_ended_queue_top.sv =====
// Bounded double-ended queue of DEPTH words held in a ring memory.
// Commands arrive on req_item (cmd and data_in) and are accepted at a rising
// edge where start is high and busy is low. The commands are push front,
// push back, pop front, pop back and no operation; unknown codes act as no
// operation.
// Each command gives exactly one result word on rsp_item, shown for a single
// cycle and marked by rsp_strobe. It carries the popped word, the front and
// back words after the step, the entry count, an empty flag and a status
// (done, rejected because empty, rejected because full).
// The strobe is high in S_DONE, which follows S_EXEC and S_LOOK after the
// accepting edge. A new command may be accepted at the edge that ends the
// strobe cycle, not before, as busy is high in S_EXEC and S_LOOK. These serve
// the two dependent memory reads: the popped entry, then the new front and back.
// The receiver cannot hold results off, so nothing ever waits at the output.
// Synchronous reset empties the queue and returns the controller to idle; the
// memory contents are not cleared, and unwritten entries never reach the outputs.
module double_ended_queue_top
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  deq_req_type req_item,
   output logic        rsp_strobe,
   output deq_rsp_type rsp_item
);

   deq_ctrl_type ctrl;

   deq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   deq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req        (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_item)
   );

endmodule
